// ===== design/mbgim_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-block grid index mapper: grid constants, request and
// response payload types, opcode enum and the reciprocal constants for division.
// No dependencies.
package mbgim_pkg;

   // Grid geometry
   localparam int unsigned X_CELLS        = 192;
   localparam int unsigned Y_CELLS_BLOCK0 = 24;
   localparam int unsigned Y_CELLS_BLOCK1 = 36;
   localparam int unsigned Y_CELLS_BLOCK2 = 25;
   localparam int unsigned Y_CELLS_BLOCK3 = 8;
   localparam int unsigned Z_CELLS        = 160;
   localparam int unsigned NUM_BLOCKS     = 4;

   // Field widths
   localparam int unsigned OP_W  = 2;
   localparam int unsigned CX_W  = 8;
   localparam int unsigned CY_W  = 7;
   localparam int unsigned CZ_W  = 8;
   localparam int unsigned BLK_W = 2;
   localparam int unsigned LID_W = 22;

   typedef enum logic [OP_W-1:0] {
      OP_TO_LINEAR = 2'd0,
      OP_TO_LOCAL  = 2'd1,
      OP_SHIFTED   = 2'd2
   } opcode_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [CX_W-1:0]   cell_x;
      logic [CY_W-1:0]   cell_y;
      logic [CZ_W-1:0]   cell_z;
      logic [BLK_W-1:0]  cell_block;
      logic [LID_W-1:0]  linear_id;
      logic [CX_W-1:0]   sample_x;
      logic [CZ_W-1:0]   sample_z;
      logic [CX_W-1:0]   origin_x;
      logic [CZ_W-1:0]   origin_z;
   } req_type;

   typedef struct packed {
      logic [LID_W-1:0]  out_linear_id;
      logic [CX_W-1:0]   out_x;
      logic [CY_W-1:0]   out_y;
      logic [CZ_W-1:0]   out_z;
      logic [BLK_W-1:0]  out_block;
      logic              range_error;
   } rsp_type;

   // Results passed from the mapping units to the top level
   typedef struct packed {
      logic [LID_W-1:0]  id;
      logic              err;
   } lin_res_type;

   typedef struct packed {
      logic [CX_W-1:0]   x;
      logic [CY_W-1:0]   y;
      logic [CZ_W-1:0]   z;
      logic [BLK_W-1:0]  blk;
      logic              err;
   } loc_res_type;

   // Elaboration-time trailing zero count
   function automatic int unsigned ctz(input int unsigned val);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 31; i++) begin
         if (((val >> i) & 1) == 0 && n == i) begin
            n = n + 1;
         end
      end
      return n;
   endfunction

   // Per-block tables
   localparam int unsigned BLK_ROWS [NUM_BLOCKS] = '{
      Y_CELLS_BLOCK0, Y_CELLS_BLOCK1, Y_CELLS_BLOCK2, Y_CELLS_BLOCK3};
   localparam int unsigned BLK_YBASE [NUM_BLOCKS] = '{
      0,
      Y_CELLS_BLOCK0,
      Y_CELLS_BLOCK0 + Y_CELLS_BLOCK1,
      Y_CELLS_BLOCK0 + Y_CELLS_BLOCK1 + Y_CELLS_BLOCK2};
   // cells in one z plane of a block
   localparam int unsigned BLK_PLANE [NUM_BLOCKS] = '{
      BLK_ROWS[0] * X_CELLS, BLK_ROWS[1] * X_CELLS,
      BLK_ROWS[2] * X_CELLS, BLK_ROWS[3] * X_CELLS};
   localparam int unsigned BLK_START [NUM_BLOCKS] = '{
      BLK_YBASE[0] * X_CELLS * Z_CELLS, BLK_YBASE[1] * X_CELLS * Z_CELLS,
      BLK_YBASE[2] * X_CELLS * Z_CELLS, BLK_YBASE[3] * X_CELLS * Z_CELLS};
   localparam int unsigned BLK_END [NUM_BLOCKS] = '{
      BLK_START[0] + BLK_PLANE[0] * Z_CELLS, BLK_START[1] + BLK_PLANE[1] * Z_CELLS,
      BLK_START[2] + BLK_PLANE[2] * Z_CELLS, BLK_START[3] + BLK_PLANE[3] * Z_CELLS};

   // Division by constants: strip the power-of-two part of X_CELLS, then
   // multiply by ceil(2^K / d) with K = N + clog2(d), exact for N-bit values.
   localparam int unsigned X_SHIFT  = ctz(X_CELLS);
   localparam int unsigned X_ODD    = X_CELLS >> X_SHIFT;
   localparam int unsigned DIV_N    = LID_W - X_SHIFT;
   localparam int unsigned DIV_M_W  = DIV_N + 1;
   localparam int unsigned PROD_W   = DIV_N + DIV_M_W;
   localparam int unsigned SHAMT_W  = $clog2(PROD_W);

   localparam int unsigned T_K = DIV_N + $clog2(X_ODD);
   localparam longint unsigned T_M = ((64'd1 << T_K) + X_ODD - 1) / X_ODD;

   localparam int unsigned Z_DIV [NUM_BLOCKS] = '{
      BLK_ROWS[0] * X_ODD, BLK_ROWS[1] * X_ODD,
      BLK_ROWS[2] * X_ODD, BLK_ROWS[3] * X_ODD};
   localparam int unsigned Z_K [NUM_BLOCKS] = '{
      DIV_N + $clog2(Z_DIV[0]), DIV_N + $clog2(Z_DIV[1]),
      DIV_N + $clog2(Z_DIV[2]), DIV_N + $clog2(Z_DIV[3])};
   localparam longint unsigned Z_M [NUM_BLOCKS] = '{
      ((64'd1 << Z_K[0]) + Z_DIV[0] - 1) / Z_DIV[0],
      ((64'd1 << Z_K[1]) + Z_DIV[1] - 1) / Z_DIV[1],
      ((64'd1 << Z_K[2]) + Z_DIV[2] - 1) / Z_DIV[2],
      ((64'd1 << Z_K[3]) + Z_DIV[3] - 1) / Z_DIV[3]};

endpackage

// ===== design/mbgim_to_linear.sv =====
`timescale 1ns / 1ps
// Local (x, y, z, block) to linear id, with the optional periodic shift of the
// sample point by reference minus origin. Depends on mbgim_pkg.
module mbgim_to_linear (
   input  mbgim_pkg::req_type     req_in,
   output mbgim_pkg::lin_res_type res_out
);
   import mbgim_pkg::*;

   localparam int unsigned SX_W = CX_W + 2;
   localparam int unsigned SZ_W = CZ_W + 2;

   logic                    shifted;
   logic                    pre_ok;
   logic signed [SX_W-1:0]  sum_x;
   logic signed [SZ_W-1:0]  sum_z;
   logic [CX_W-1:0]         nx;
   logic [CZ_W-1:0]         nz;
   logic [CX_W-1:0]         x_sel;
   logic [CZ_W-1:0]         z_sel;
   logic [BLK_W-1:0]        blk;
   logic                    x_ok;
   logic                    z_ok;
   logic                    y_ok;
   logic [CY_W-1:0]         y_loc;

   assign shifted = (req_in.opcode == OP_SHIFTED);

   assign pre_ok = (32'(req_in.sample_x) < X_CELLS) && (32'(req_in.cell_x) < X_CELLS) &&
                   (32'(req_in.origin_x) < X_CELLS) && (32'(req_in.sample_z) < Z_CELLS) &&
                   (32'(req_in.cell_z) < Z_CELLS) && (32'(req_in.origin_z) < Z_CELLS);

   // single periodic wrap in x and z
   always_comb begin
      sum_x = $signed(SX_W'(req_in.sample_x)) + $signed(SX_W'(req_in.cell_x))
            - $signed(SX_W'(req_in.origin_x));
      priority if (sum_x < 0) begin
         nx = CX_W'(sum_x + $signed(SX_W'(X_CELLS)));
      end else if (sum_x >= $signed(SX_W'(X_CELLS))) begin
         nx = CX_W'(sum_x - $signed(SX_W'(X_CELLS)));
      end else begin
         nx = CX_W'(sum_x);
      end

      sum_z = $signed(SZ_W'(req_in.sample_z)) + $signed(SZ_W'(req_in.cell_z))
            - $signed(SZ_W'(req_in.origin_z));
      priority if (sum_z < 0) begin
         nz = CZ_W'(sum_z + $signed(SZ_W'(Z_CELLS)));
      end else if (sum_z >= $signed(SZ_W'(Z_CELLS))) begin
         nz = CZ_W'(sum_z - $signed(SZ_W'(Z_CELLS)));
      end else begin
         nz = CZ_W'(sum_z);
      end
   end

   assign x_sel = shifted ? nx : req_in.cell_x;
   assign z_sel = shifted ? nz : req_in.cell_z;
   assign blk   = req_in.cell_block;

   assign x_ok  = 32'(x_sel) < X_CELLS;
   assign z_ok  = 32'(z_sel) < Z_CELLS;
   assign y_ok  = (32'(req_in.cell_y) >= BLK_YBASE[blk]) &&
                  (32'(req_in.cell_y) < BLK_YBASE[blk] + BLK_ROWS[blk]);
   assign y_loc = CY_W'(req_in.cell_y - CY_W'(BLK_YBASE[blk]));

   // id = start + z * plane + y_local * X + x; products are independent
   assign res_out.id = LID_W'(BLK_START[blk])
                     + LID_W'(LID_W'(z_sel) * LID_W'(BLK_PLANE[blk]))
                     + LID_W'(LID_W'(y_loc) * LID_W'(X_CELLS))
                     + LID_W'(x_sel);
   assign res_out.err = !(x_ok && z_ok && y_ok && (!shifted || pre_ok));

endmodule

// ===== design/mbgim_to_local.sv =====
`timescale 1ns / 1ps
// Linear id to local (x, global y, z, block): block select by bounds compare,
// then constant divisions by reciprocal multiply. Depends on mbgim_pkg.
module mbgim_to_local (
   input  logic [mbgim_pkg::LID_W-1:0] linear_id,
   output mbgim_pkg::loc_res_type      res_out
);
   import mbgim_pkg::*;

   logic [BLK_W-1:0]   blk;
   logic [LID_W-1:0]   loc;
   logic [DIV_N-1:0]   v;
   logic [PROD_W-1:0]  t_prod;
   logic [PROD_W-1:0]  z_prod;
   logic [SHAMT_W-1:0] z_shamt;
   logic [DIV_N-1:0]   t;
   logic [CZ_W-1:0]    z;
   logic [DIV_N-1:0]   y_loc;

   always_comb begin
      priority if (32'(linear_id) < BLK_END[0]) begin
         blk = BLK_W'(0);
      end else if (32'(linear_id) < BLK_END[1]) begin
         blk = BLK_W'(1);
      end else if (32'(linear_id) < BLK_END[2]) begin
         blk = BLK_W'(2);
      end else begin
         blk = BLK_W'(3);
      end
   end

   assign loc = linear_id - LID_W'(BLK_START[blk]);
   assign v   = loc[LID_W-1:X_SHIFT];

   // t = loc / X_CELLS, z = loc / (rows * X_CELLS), computed side by side
   assign t_prod  = PROD_W'(v) * PROD_W'(T_M);
   assign t       = DIV_N'(t_prod >> T_K);
   assign z_prod  = PROD_W'(v) * PROD_W'(Z_M[blk]);
   assign z_shamt = SHAMT_W'(Z_K[blk]);
   assign z       = CZ_W'(z_prod >> z_shamt);

   assign y_loc = DIV_N'(t - DIV_N'(DIV_N'(z) * DIV_N'(BLK_ROWS[blk])));

   assign res_out.x   = CX_W'(loc - LID_W'(LID_W'(t) * LID_W'(X_CELLS)));
   assign res_out.y   = CY_W'(y_loc + DIV_N'(BLK_YBASE[blk]));
   assign res_out.z   = z;
   assign res_out.blk = blk;
   assign res_out.err = 32'(linear_id) >= BLK_END[NUM_BLOCKS-1];

endmodule

// ===== design/multi_block_grid_index_mapper_core.sv =====
`timescale 1ns / 1ps
// Multi-block grid index mapper, top level: input register, the two mapping
// units and the response register. Depends on mbgim_pkg, mbgim_to_linear, mbgim_to_local.
//
// Usage:
//   req_* channel: valid/ready; one request per transfer on req_data. The opcode
//   picks local-to-linear, linear-to-local or the periodic shifted sample id.
//   rsp_* channel: valid/ready; exactly one response per request, in order.
//   Fields an opcode does not produce are zero; an index outside the grid or
//   an unused opcode gives range_error = 1 with all other fields zero.
// Timing: a request taken is held in the input register, mapped in a single
//   combinational pass and then captured in the response register.
// Throughput: one request per cycle while rsp_ready does not stall the response register;
//   the arithmetic between the two registers is constant multiplies, adds, subtracts and compares.
// Reset: synchronous, active high; empties both pipeline registers. The block
//   has no other state.
// Stall: while rsp_ready is low with a response held, the input register
//   still takes one more request; req_ready then drops until the response
//   register frees up. Nothing is dropped or repeated.
module multi_block_grid_index_mapper_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mbgim_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mbgim_pkg::rsp_type rsp_data
);
   import mbgim_pkg::*;

   logic        req_vld_ff;
   logic        req_vld_in;
   req_type     req_ff;
   logic        rsp_vld_ff;
   logic        rsp_vld_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic        advance;
   lin_res_type lin_res;
   loc_res_type loc_res;

   assign advance    = !rsp_vld_ff || rsp_ready;
   assign req_ready  = !req_vld_ff || advance;
   assign req_vld_in = req_ready ? req_valid : req_vld_ff;
   assign rsp_vld_in = advance ? req_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance && req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   mbgim_to_linear u_to_linear (
      .req_in  (req_ff),
      .res_out (lin_res)
   );

   mbgim_to_local u_to_local (
      .linear_id (req_ff.linear_id),
      .res_out   (loc_res)
   );

   always_comb begin
      rsp_in = '0;
      unique case (req_ff.opcode)
         OP_TO_LINEAR, OP_SHIFTED: begin
            if (lin_res.err) begin
               rsp_in.range_error = 1'b1;
            end else begin
               rsp_in.out_linear_id = lin_res.id;
            end
         end
         OP_TO_LOCAL: begin
            if (loc_res.err) begin
               rsp_in.range_error = 1'b1;
            end else begin
               rsp_in.out_x     = loc_res.x;
               rsp_in.out_y     = loc_res.y;
               rsp_in.out_z     = loc_res.z;
               rsp_in.out_block = loc_res.blk;
            end
         end
         default: begin
            rsp_in.range_error = 1'b1;
         end
      endcase
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
